@@ design/ahics_pkg.sv @@
package ahics_pkg;

  localparam int unsigned TICK_COUNT_WIDTH = 16;

  localparam int unsigned VOLT_W = 10;
  localparam int unsigned MACH_W = 9;
  localparam int unsigned TLIM_W = 16;
  localparam int unsigned SEC_W  = 9;
  localparam int unsigned PROD_W = TICK_COUNT_WIDTH + TLIM_W;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [SEC_W-1:0]  SEC_WRAP  = SEC_W'(480);
  localparam logic [SEC_W-1:0]  SEC_MAX   = SEC_W'(481);
  localparam logic [PROD_W-1:0] TICK_BASE = PROD_W'(1000);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MACH_LIMIT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT        = 2'd2;

  localparam logic [VOLT_W-1:0] VTH_RESET  = VOLT_W'(180);
  localparam logic [MACH_W-1:0] MACH_RESET = MACH_W'(125);
  localparam logic [TLIM_W-1:0] TLIM_RESET = TLIM_W'(10);

  // selector positions
  localparam logic [1:0] SEL_OFF    = 2'd0;
  localparam logic [1:0] SEL_LONG   = 2'd1;
  localparam logic [1:0] SEL_FIRST  = 2'd2;
  localparam logic [1:0] SEL_SECOND = 2'd3;

  // result tdata bit positions
  localparam int unsigned OUT_ENABLE_BIT  = 0;
  localparam int unsigned OUT_BLOCK_BIT   = 1;
  localparam int unsigned OUT_INHIBIT_BIT = 2;
  localparam int unsigned OUT_ACTIVE_LSB  = 3;
  localparam int unsigned OUT_SEC_A_BIT   = 5;
  localparam int unsigned OUT_SEC_B_BIT   = 6;
  localparam int unsigned OUT_SEC_C_BIT   = 7;
  localparam int unsigned OUT_SEC_D_BIT   = 8;
  localparam int unsigned OUT_ELAPSED_LSB = 9;

  // program slot, also the counter index
  typedef enum logic [1:0] {
    PROG_FIRST  = 2'd0,
    PROG_SECOND = 2'd1,
    PROG_LONG   = 2'd2,
    PROG_NONE   = 2'd3
  } prog_e;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } sections_t;

  typedef struct packed {
    logic [VOLT_W-1:0] bus_a_voltage;
    logic [VOLT_W-1:0] bus_b_voltage;
    logic [MACH_W-1:0] mach_number;
    logic              intake_fault;
    logic [1:0]        program_switch;
    logic              anti_ice_switch;
    logic              relay_k27_in;
  } in_item_t;

  function automatic logic in_window(logic [SEC_W-1:0] s, logic [SEC_W-1:0] lo,
                                     logic [SEC_W-1:0] hi);
    return (s >= lo) && (s < hi);
  endfunction

endpackage

@@ design/ahics_window_decode.sv @@
module ahics_window_decode (
  input  ahics_pkg::prog_e                 prog_i,
  input  logic [ahics_pkg::SEC_W-1:0]      sec_i,
  output ahics_pkg::sections_t             sections_o
);
  import ahics_pkg::*;

  logic a_short;

  // section a pattern shared by the first and second programs
  assign a_short = in_window(sec_i, 9'd0, 9'd20) || in_window(sec_i, 9'd120, 9'd140) ||
                   in_window(sec_i, 9'd240, 9'd260) || in_window(sec_i, 9'd360, 9'd380);

  always_comb begin
    sections_o = '0;
    case (prog_i)
      PROG_FIRST: begin
        sections_o.a = a_short;
        sections_o.c = in_window(sec_i, 9'd401, 9'd420);
        sections_o.d = in_window(sec_i, 9'd161, 9'd180) ||
                       in_window(sec_i, 9'd441, 9'd460);
      end
      PROG_SECOND: begin
        sections_o.a = a_short;
        sections_o.b = in_window(sec_i, 9'd40, 9'd60) || in_window(sec_i, 9'd280, 9'd300);
        sections_o.c = in_window(sec_i, 9'd160, 9'd180) ||
                       in_window(sec_i, 9'd400, 9'd420);
        sections_o.d = in_window(sec_i, 9'd440, 9'd460);
      end
      PROG_LONG: begin
        sections_o.a = in_window(sec_i, 9'd0, 9'd60) || in_window(sec_i, 9'd240, 9'd300);
        sections_o.b = in_window(sec_i, 9'd120, 9'd180) ||
                       in_window(sec_i, 9'd360, 9'd420);
        sections_o.c = in_window(sec_i, 9'd180, 9'd240) ||
                       in_window(sec_i, 9'd420, SEC_WRAP);
        sections_o.d = in_window(sec_i, 9'd300, 9'd360);
      end
      default: sections_o = '0;
    endcase
  end

endmodule

@@ design/anti_ice_heater_cycle_sequencer.sv @@
// Anti-ice heater cycle sequencer.
// Input stream (s_axis_*): one transfer per timer tick with bus voltages, Mach
// number, intake fault, program selector, anti-ice switch and relay contact.
// Output stream (m_axis_*): one transfer per tick with the three relays, the
// running program, four heater section drives and the elapsed seconds.
// Config port (cfg_*): index 0 voltage threshold, 1 Mach limit, 2 tick limit;
// always ready; the user must write it only while the stream is idle (unchecked).
// Result valid rises once the tick has passed the input register and then the
// result register, and the result transfers from there.
// Throughput is one tick per cycle while the receiver is ready: the path between the two registers is one
// tick-count by tick-limit multiply and compare plus the window decode.
// Reset clears both pipeline valid flags, all tick and seconds counters and loads
// the register defaults (180, 125, 10).
// When the receiver stalls the result is held and an empty input register still
// takes one more tick; after that s_axis_tready drops until the result moves.
module anti_ice_heater_cycle_sequencer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // bus_a_voltage[9:0], bus_b_voltage[19:10], mach_number[28:20],
  // intake_fault[29], program_switch[31:30], anti_ice_switch[32],
  // relay_k27_in[33], zero pad[39:34]
  input  logic [ahics_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // heat_enable[0], block_relay[1], inhibit_relay[2], active_program[4:3],
  // heater_section_a[5], b[6], c[7], d[8], elapsed_seconds[17:9], zero pad[23:18]
  output logic [ahics_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ahics_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ahics_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ahics_pkg::*;

  logic [VOLT_W-1:0] vth_q;
  logic [MACH_W-1:0] mach_lim_q;
  logic [TLIM_W-1:0] tick_lim_q;

  logic     in_valid_q;
  in_item_t in_q;
  logic     out_valid_q;
  logic [OUT_TDATA_W-1:0] out_q, out_d;

  logic [TICK_COUNT_WIDTH-1:0] tick_q [3];
  logic [SEC_W-1:0]            sec_q  [3];

  logic advance, step;
  logic a_ok, enable, block, inhibit, run;
  prog_e prog;
  logic [TICK_COUNT_WIDTH-1:0] tick_cur, tick_inc, tick_new;
  logic [SEC_W-1:0] sec_cur, sec_new, sec_store;
  logic [PROD_W-1:0] prod;
  logic sec_tick, wrap;
  sections_t sections, sections_run;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vth_q      <= VTH_RESET;
      mach_lim_q <= MACH_RESET;
      tick_lim_q <= TLIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOLTAGE_THRESHOLD: vth_q      <= cfg_data_i[VOLT_W-1:0];
        REG_MACH_LIMIT:        mach_lim_q <= cfg_data_i[MACH_W-1:0];
        REG_TICK_LIMIT:        tick_lim_q <= cfg_data_i[TLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.bus_a_voltage   <= s_axis_tdata[9:0];
      in_q.bus_b_voltage   <= s_axis_tdata[19:10];
      in_q.mach_number     <= s_axis_tdata[28:20];
      in_q.intake_fault    <= s_axis_tdata[29];
      in_q.program_switch  <= s_axis_tdata[31:30];
      in_q.anti_ice_switch <= s_axis_tdata[32];
      in_q.relay_k27_in    <= s_axis_tdata[33];
    end
  end

  // relay logic
  assign a_ok    = in_q.bus_a_voltage >= vth_q;
  assign enable  = a_ok && (in_q.mach_number <= mach_lim_q);
  assign block   = a_ok && in_q.anti_ice_switch;
  assign inhibit = (in_q.bus_b_voltage >= vth_q) && !block && in_q.relay_k27_in;
  assign run     = !inhibit && enable && !in_q.intake_fault &&
                   (in_q.program_switch != SEL_OFF);

  always_comb begin
    case (in_q.program_switch)
      SEL_FIRST:  prog = PROG_FIRST;
      SEL_SECOND: prog = PROG_SECOND;
      SEL_LONG:   prog = PROG_LONG;
      default:    prog = PROG_NONE;
    endcase
    if (!run) begin
      prog = PROG_NONE;
    end
  end

  always_comb begin
    case (prog)
      PROG_FIRST, PROG_SECOND, PROG_LONG: begin
        tick_cur = tick_q[prog];
        sec_cur  = sec_q[prog];
      end
      default: begin
        tick_cur = '0;
        sec_cur  = '0;
      end
    endcase
  end

  // prescaler: a second elapses once ticks times tick limit passes the base
  assign tick_inc  = tick_cur + TICK_COUNT_WIDTH'(1);
  assign prod      = PROD_W'(tick_inc) * PROD_W'(tick_lim_q);
  assign sec_tick  = prod > TICK_BASE;
  assign sec_new   = sec_tick ? sec_cur + SEC_W'(1) : sec_cur;
  assign wrap      = sec_new > SEC_WRAP;
  assign tick_new  = (sec_tick || wrap) ? '0 : tick_inc;
  assign sec_store = wrap ? '0 : sec_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        tick_q[i] <= '0;
        sec_q[i]  <= '0;
      end
    end else if (step) begin
      // counters of programs that are not running are cleared every tick
      for (int i = 0; i < 3; i++) begin
        if (prog == prog_e'(i)) begin
          tick_q[i] <= tick_new;
          sec_q[i]  <= sec_store;
        end else begin
          tick_q[i] <= '0;
          sec_q[i]  <= '0;
        end
      end
    end
  end

  ahics_window_decode u_decode (
    .prog_i     (prog),
    .sec_i      (sec_new),
    .sections_o (sections)
  );

  assign sections_run = run ? sections : '0;

  always_comb begin
    out_d = '0;
    out_d[OUT_ENABLE_BIT]  = enable;
    out_d[OUT_BLOCK_BIT]   = block;
    out_d[OUT_INHIBIT_BIT] = inhibit;
    out_d[OUT_ACTIVE_LSB +: 2] = run ? in_q.program_switch : SEL_OFF;
    out_d[OUT_SEC_A_BIT]   = sections_run.a;
    out_d[OUT_SEC_B_BIT]   = sections_run.b;
    out_d[OUT_SEC_C_BIT]   = sections_run.c;
    out_d[OUT_SEC_D_BIT]   = sections_run.d;
    out_d[OUT_ELAPSED_LSB +: SEC_W] = run ? sec_new : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ design/ahics_checker.sv @@
module ahics_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ahics_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ahics_pkg::*;

  logic [1:0]       active;
  logic [SEC_W-1:0] elapsed;
  logic [3:0]       secs;

  assign active  = m_axis_tdata[OUT_ACTIVE_LSB +: 2];
  assign elapsed = m_axis_tdata[OUT_ELAPSED_LSB +: SEC_W];
  assign secs    = m_axis_tdata[OUT_SEC_D_BIT:OUT_SEC_A_BIT];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (active == SEL_OFF) |-> (secs == 4'b0) && (elapsed == '0))
    else $error("heater drive or seconds with no program running");

  a_run_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (active != SEL_OFF) |->
      m_axis_tdata[OUT_ENABLE_BIT] && !m_axis_tdata[OUT_INHIBIT_BIT])
    else $error("program running while heating not allowed");

  a_first_no_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (active == SEL_FIRST) |-> !m_axis_tdata[OUT_SEC_B_BIT])
    else $error("section b driven by first program");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> elapsed <= SEC_MAX)
    else $error("elapsed seconds out of range");

endmodule

bind anti_ice_heater_cycle_sequencer ahics_checker u_ahics_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/anti_ice_heater_cycle_sequencer_tb.sv @@
module anti_ice_heater_cycle_sequencer_tb;
  import ahics_pkg::*;

  localparam int unsigned STALL_LIMIT = 500;

  typedef struct packed {
    logic              heat_enable;
    logic              block_relay;
    logic              inhibit_relay;
    logic [1:0]        active_program;
    sections_t         sections;
    logic [SEC_W-1:0]  elapsed_seconds;
  } heater_result_t;

  // tracks the relay logic and the three program counters, holds the results still owed
  class heater_scoreboard;
    logic [VOLT_W-1:0]           vth;
    logic [MACH_W-1:0]           mach_lim;
    logic [TLIM_W-1:0]           tlim;
    logic [TICK_COUNT_WIDTH-1:0] ticks [3];
    logic [SEC_W-1:0]            secs [3];
    heater_result_t              owed_q [$];
    int unsigned                 errors;

    function new();
      vth = VTH_RESET;
      mach_lim = MACH_RESET;
      tlim = TLIM_RESET;
      for (int i = 0; i < 3; i++) begin
        ticks[i] = '0;
        secs[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_VOLTAGE_THRESHOLD: vth = data[VOLT_W-1:0];
        REG_MACH_LIMIT:        mach_lim = data[MACH_W-1:0];
        REG_TICK_LIMIT:        tlim = data[TLIM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit in_span(logic [SEC_W-1:0] s, int unsigned lo, int unsigned hi);
      return (s >= lo) && (s < hi);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_tick(in_item_t it);
      heater_result_t              r;
      prog_e                       slot;
      logic                        a_ok;
      logic [TICK_COUNT_WIDTH-1:0] t;
      logic [SEC_W-1:0]            s;
      longint unsigned             prod;
      r = '0;
      a_ok = it.bus_a_voltage >= vth;
      r.heat_enable = a_ok && (it.mach_number <= mach_lim);
      r.block_relay = a_ok && it.anti_ice_switch;
      r.inhibit_relay = (it.bus_b_voltage >= vth) && !r.block_relay && it.relay_k27_in;
      slot = PROG_NONE;
      if (!r.inhibit_relay && r.heat_enable && !it.intake_fault) begin
        case (it.program_switch)
          SEL_FIRST:  slot = PROG_FIRST;
          SEL_SECOND: slot = PROG_SECOND;
          SEL_LONG:   slot = PROG_LONG;
          default:    slot = PROG_NONE;
        endcase
      end
      // idle programs lose their counts every tick
      for (int i = 0; i < 3; i++) begin
        if (i != int'(slot)) begin
          ticks[i] = '0;
          secs[i] = '0;
        end
      end
      if (slot != PROG_NONE) begin
        t = ticks[slot] + 1'b1;
        s = secs[slot];
        prod = longint'(t) * longint'(tlim);
        if (prod > 1000) begin
          s = s + 1'b1;
          t = '0;
        end
        r.active_program = it.program_switch;
        r.elapsed_seconds = s;
        case (slot)
          PROG_FIRST: begin
            r.sections.a = (s < 20) || in_span(s, 120, 140) || in_span(s, 240, 260) ||
                           in_span(s, 360, 380);
            r.sections.c = (s > 400) && (s < 420);
            r.sections.d = ((s > 160) && (s < 180)) || ((s > 440) && (s < 460));
          end
          PROG_SECOND: begin
            r.sections.a = (s < 20) || in_span(s, 120, 140) || in_span(s, 240, 260) ||
                           in_span(s, 360, 380);
            r.sections.b = in_span(s, 40, 60) || in_span(s, 280, 300);
            r.sections.c = in_span(s, 160, 180) || in_span(s, 400, 420);
            r.sections.d = in_span(s, 440, 460);
          end
          default: begin
            r.sections.a = (s < 60) || in_span(s, 240, 300);
            r.sections.b = in_span(s, 120, 180) || in_span(s, 360, 420);
            r.sections.c = in_span(s, 180, 240) || in_span(s, 420, 480);
            r.sections.d = in_span(s, 300, 360);
          end
        endcase
        // wrap happens after the decode, so 481 is reported once
        if (s > SEC_WRAP) begin
          s = '0;
          t = '0;
        end
        ticks[slot] = t;
        secs[slot] = s;
      end
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      heater_result_t r;
      if (owed_q.size() == 0) begin
        $error("result 0x%0h arrived with nothing outstanding", d);
        errors++;
      end else begin
        r = owed_q.pop_front();
        compare_field("heat_enable", r.heat_enable, d[OUT_ENABLE_BIT]);
        compare_field("block_relay", r.block_relay, d[OUT_BLOCK_BIT]);
        compare_field("inhibit_relay", r.inhibit_relay, d[OUT_INHIBIT_BIT]);
        compare_field("active_program", r.active_program, d[OUT_ACTIVE_LSB +: 2]);
        compare_field("heater_section_a", r.sections.a, d[OUT_SEC_A_BIT]);
        compare_field("heater_section_b", r.sections.b, d[OUT_SEC_B_BIT]);
        compare_field("heater_section_c", r.sections.c, d[OUT_SEC_C_BIT]);
        compare_field("heater_section_d", r.sections.d, d[OUT_SEC_D_BIT]);
        compare_field("elapsed_seconds", r.elapsed_seconds, d[OUT_ELAPSED_LSB +: SEC_W]);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  heater_scoreboard sb;
  int unsigned      rx_hold = 0;
  int unsigned      idle_cycles = 0;
  bit               rx_quiet = 1'b0;
  bit               tx_quiet = 1'b0;

  anti_ice_heater_cycle_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check each transfer, then draw the stall before the next one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
      rx_hold = rx_quiet ? 0 : $urandom_range(7, 0);
      if ($urandom_range(39, 0) == 0) rx_quiet = !rx_quiet;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (rx_hold != 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("anti_ice_heater_cycle_sequencer_tb: done, errors");
      $finish;
    end
  end

  function automatic in_item_t make_tick(int unsigned bus_a, int unsigned bus_b,
                                         int unsigned mach, bit fault, logic [1:0] sel,
                                         bit anti_ice, bit k27);
    in_item_t it;
    it.bus_a_voltage = bus_a;
    it.bus_b_voltage = bus_b;
    it.mach_number = mach;
    it.intake_fault = fault;
    it.program_switch = sel;
    it.anti_ice_switch = anti_ice;
    it.relay_k27_in = k27;
    return it;
  endfunction

  function automatic in_item_t random_tick();
    return make_tick($urandom_range(1023, 0), $urandom_range(1023, 0),
                     $urandom_range(511, 0), $urandom_range(1, 0), $urandom_range(3, 0),
                     $urandom_range(1, 0), $urandom_range(1, 0));
  endfunction

  // a tick that lets the selected program run, with the free fields random
  function automatic in_item_t good_tick(logic [1:0] sel);
    in_item_t it;
    it = make_tick($urandom_range(1023, sb.vth), $urandom_range(1023, 0),
                   $urandom_range(sb.mach_lim, 0), 1'b0, sel, $urandom_range(1, 0),
                   $urandom_range(1, 0));
    if (!it.anti_ice_switch && it.relay_k27_in && it.bus_b_voltage >= sb.vth) begin
      case ($urandom_range(2, 0))
        0: it.anti_ice_switch = 1'b1;
        1: it.relay_k27_in = 1'b0;
        default: begin
          if (sb.vth != 0) it.bus_b_voltage = $urandom_range(sb.vth - 1, 0);
          else it.relay_k27_in = 1'b0;
        end
      endcase
    end
    return it;
  endfunction

  task automatic send_tick(input in_item_t it);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(7, 0);
    if ($urandom_range(39, 0) == 0) tx_quiet = !tx_quiet;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = IN_TDATA_W'({it.relay_k27_in, it.anti_ice_switch, it.program_switch,
                                it.intake_fault, it.mach_number, it.bus_b_voltage,
                                it.bus_a_voltage});
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, cfg_data_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(int unsigned vth, int unsigned mach, int unsigned tlim);
    wait_drained();
    write_reg(REG_VOLTAGE_THRESHOLD, vth);
    write_reg(REG_MACH_LIMIT, mach);
    write_reg(REG_TICK_LIMIT, tlim);
  endtask

  task automatic run_phase(int unsigned n, int unsigned noise_pct, int unsigned switch_pct);
    logic [1:0] sel;
    sel = $urandom_range(3, 1);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99, 0) < switch_pct) sel = $urandom_range(3, 0);
      if ($urandom_range(99, 0) < noise_pct) send_tick(random_tick());
      else send_tick(good_tick(sel));
      if ($urandom_range(249, 0) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_VOLTAGE_THRESHOLD;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: threshold 180, mach limit 125, tick limit 10
    send_tick(make_tick(0, 0, 0, 0, SEL_OFF, 0, 0));
    send_tick(make_tick(1023, 1023, 511, 1, SEL_SECOND, 1, 1));
    send_tick(make_tick(1023, 0, 0, 0, SEL_FIRST, 1, 0));
    send_tick(make_tick(1023, 0, 0, 0, SEL_SECOND, 0, 0));
    send_tick(make_tick(1023, 0, 0, 0, SEL_LONG, 0, 1));
    send_tick(make_tick(1023, 0, 0, 0, SEL_OFF, 1, 1));
    // threshold and mach limit edges
    send_tick(make_tick(180, 0, 125, 0, SEL_LONG, 0, 0));
    send_tick(make_tick(180, 0, 126, 0, SEL_LONG, 0, 0));
    send_tick(make_tick(179, 0, 0, 0, SEL_LONG, 1, 0));
    // inhibit raised by bus b and the contact while block is off
    send_tick(make_tick(1023, 180, 0, 0, SEL_FIRST, 0, 1));
    send_tick(make_tick(1023, 179, 0, 0, SEL_FIRST, 0, 1));
    send_tick(make_tick(0, 1023, 511, 0, SEL_SECOND, 0, 1));
    // block relay holds inhibit off; one pattern with block off raises inhibit
    send_tick(make_tick(1023, 1023, 0, 0, SEL_FIRST, 1, 1));
    send_tick(make_tick(1023, 1023, 0, 1, SEL_FIRST, 1, 1));
    send_tick(make_tick(10'h2aa, 10'h155, 9'h0aa, 0, SEL_SECOND, 1, 0));
    send_tick(make_tick(10'h355, 10'h2aa, 9'h055, 0, SEL_LONG, 0, 1));
    send_tick(make_tick(1023, 0, 0, 0, SEL_LONG, 1, 1));

    // one second per tick and nothing blocking: runs a program past its wrap
    configure(0, 511, 65535);
    run_phase(500, 0, 0);
    configure($urandom_range(400, 0), $urandom_range(511, 0), $urandom_range(2000, 1));
    run_phase(150, 10, 3);
    configure(1023, 0, 1);
    run_phase(60, 30, 10);
    // a zero tick limit never lets a second pass
    configure($urandom_range(400, 0), $urandom_range(511, 0), 0);
    run_phase(60, 10, 5);
    configure($urandom_range(1023, 0), $urandom_range(511, 0), $urandom_range(65535, 1001));
    run_phase(80, 5, 2);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("anti_ice_heater_cycle_sequencer_tb: done, clean");
    end else begin
      $display("anti_ice_heater_cycle_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
